// ===== hdl/scc_pkg.sv =====
package scc_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 256;
  localparam int ID_WIDTH  = 64;

  localparam int NIDX_W = $clog2(MAX_NODES);
  localparam int NCNT_W = $clog2(MAX_NODES + 1);
  localparam int EIDX_W = $clog2(MAX_EDGES);
  localparam int ECNT_W = $clog2(MAX_EDGES + 1);
  localparam int ORD_W  = NCNT_W;
  localparam int COMP_W = 6;

  localparam logic [ID_WIDTH-1:0] SIGN_FLIP = {1'b1, {(ID_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_NODE = 2'd0,
    OP_EDGE = 2'd1,
    OP_RUN  = 2'd2,
    OP_NONE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_MEMBER = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_ERROR  = 2'd2,
    ST_UNUSED = 2'd3
  } status_e;

  typedef struct packed {
    logic [ID_WIDTH-1:0] id;
    logic [COMP_W-1:0]   comp;
    logic                last_comp;
    logic                last_all;
    status_e             status;
  } res_t;

endpackage

// ===== hdl/strongly_connected_components.sv =====
// Channel | Dir | Handshake              | Beat carries
// in      | in  | in_valid_i/in_ready_o  | opcode_i, node_id_i, edge_target_id_i
// out     | out | out_valid_o/out_ready_i| member_id_o, component_number_o,
//         |     |                        | last_in_component_o, last_overall_o,
//         |     |                        | run_status_o
//
// Loads are accepted one per cycle, back to back. A run walks the graph with
// one sequencer around simple dual-port RAMs: each scanned edge is read and its
// source compared, a matching source starts a binary search over the sorted
// ids (up to log2(node count)+1 probes), a visit reads the node's id, a closed
// frame is written back before returning to its parent, and members are popped.
// in_ready_o is low for the whole run. Output stalls freeze the sequencer
// only where a member is emitted and on the final beat. No clearing pass:
// reset and run start clear visited and on-stack bits at once; tables are
// valid by their counts.
module strongly_connected_components import scc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 opcode_i,
  input  logic signed [ID_WIDTH-1:0] node_id_i,
  input  logic signed [ID_WIDTH-1:0] edge_target_id_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [ID_WIDTH-1:0] member_id_o,
  output logic [COMP_W-1:0]          component_number_o,
  output logic                       last_in_component_o,
  output logic                       last_overall_o,
  output logic [1:0]                 run_status_o
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_ROOT  = 17'h00002,
    S_VID   = 17'h00004,
    S_EDGE  = 17'h00008,
    S_ECMP  = 17'h00010,
    S_BS    = 17'h00020,
    S_BSC   = 17'h00040,
    S_TCHK  = 17'h00080,
    S_TORD  = 17'h00100,
    S_END   = 17'h00200,
    S_POP   = 17'h00400,
    S_POPW  = 17'h00800,
    S_POPE  = 17'h01000,
    S_RET   = 17'h02000,
    S_RET1  = 17'h04000,
    S_RET2  = 17'h08000,
    S_FLUSH = 17'h10000
  } state_e;

  localparam int VL_W = 2 * ORD_W;
  localparam int WK_W = NIDX_W + ECNT_W;

  state_e state_q, state_d;

  // load-side stores
  logic [NCNT_W-1:0]   nc_q, nc_d;
  logic [ECNT_W-1:0]   ec_q, ec_d;
  logic                err_q, err_d;
  logic [ID_WIDTH-1:0] lastkey_q, lastkey_d;

  // search registers
  logic [NCNT_W-1:0]   r_q, r_d;
  logic [ORD_W-1:0]    ord_q, ord_d;
  logic [COMP_W-1:0]   comp_q, comp_d;
  logic [NCNT_W-1:0]   msp_q, msp_d;
  logic [NCNT_W-1:0]   wsp_q, wsp_d;
  logic [NIDX_W-1:0]   v_q, v_d;
  logic [ECNT_W-1:0]   e_q, e_d;
  logic [ID_WIDTH-1:0] vid_q, vid_d;
  logic [ORD_W-1:0]    ordv_q, ordv_d;
  logic [ORD_W-1:0]    lowv_q, lowv_d;
  logic [NCNT_W-1:0]   lo_q, lo_d;
  logic [NCNT_W-1:0]   hix_q, hix_d;
  logic [NIDX_W-1:0]   mid_q, mid_d;
  logic [NIDX_W-1:0]   t_q, t_d;
  logic [ID_WIDTH-1:0] tkey_q, tkey_d;
  logic [NIDX_W-1:0]   w_q, w_d;
  logic [MAX_NODES-1:0] visited_q, visited_d;
  logic [MAX_NODES-1:0] onstk_q, onstk_d;

  // result hold stage and output register
  res_t pend_q, pend_d;
  logic pend_vld_q, pend_vld_d;
  res_t out_q, out_d;
  logic out_vld_q, out_vld_d;

  // RAM ports
  logic                node_we, node_re;
  logic [NIDX_W-1:0]   node_waddr, node_raddr;
  logic [ID_WIDTH-1:0] node_wdata, node_rdata;
  logic                edge_we, edge_re;
  logic [ID_WIDTH-1:0] src_rdata, tgt_rdata;
  logic                vl_we, vl_re;
  logic [NIDX_W-1:0]   vl_waddr, vl_raddr;
  logic [VL_W-1:0]     vl_wdata, vl_rdata;
  logic                mem_we, mem_re;
  logic [NIDX_W-1:0]   mem_waddr, mem_raddr, mem_wdata, mem_rdata;
  logic                wk_we, wk_re;
  logic [NIDX_W-1:0]   wk_waddr, wk_raddr;
  logic [WK_W-1:0]     wk_wdata, wk_rdata;

  logic                do_visit;
  logic [NIDX_W-1:0]   vis_idx;
  logic                can_push;
  logic [NCNT_W:0]     mid_sum;
  logic [ID_WIDTH-1:0] mkey;
  logic [ORD_W-1:0]    t_ord;

  scc_ram #(.Width(ID_WIDTH), .Depth(MAX_NODES)) u_node_ram (
    .clk_i, .we_i(node_we), .waddr_i(node_waddr), .wdata_i(node_wdata),
    .re_i(node_re), .raddr_i(node_raddr), .rdata_o(node_rdata)
  );
  scc_ram #(.Width(ID_WIDTH), .Depth(MAX_EDGES)) u_src_ram (
    .clk_i, .we_i(edge_we), .waddr_i(ec_q[EIDX_W-1:0]), .wdata_i(node_id_i),
    .re_i(edge_re), .raddr_i(e_q[EIDX_W-1:0]), .rdata_o(src_rdata)
  );
  scc_ram #(.Width(ID_WIDTH), .Depth(MAX_EDGES)) u_tgt_ram (
    .clk_i, .we_i(edge_we), .waddr_i(ec_q[EIDX_W-1:0]),
    .wdata_i(edge_target_id_i),
    .re_i(edge_re), .raddr_i(e_q[EIDX_W-1:0]), .rdata_o(tgt_rdata)
  );
  // {visit order, lowest reach} per node
  scc_ram #(.Width(VL_W), .Depth(MAX_NODES)) u_vl_ram (
    .clk_i, .we_i(vl_we), .waddr_i(vl_waddr), .wdata_i(vl_wdata),
    .re_i(vl_re), .raddr_i(vl_raddr), .rdata_o(vl_rdata)
  );
  scc_ram #(.Width(NIDX_W), .Depth(MAX_NODES)) u_member_ram (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .re_i(mem_re), .raddr_i(mem_raddr), .rdata_o(mem_rdata)
  );
  // saved ancestor frames {node, next edge}
  scc_ram #(.Width(WK_W), .Depth(MAX_NODES)) u_walk_ram (
    .clk_i, .we_i(wk_we), .waddr_i(wk_waddr), .wdata_i(wk_wdata),
    .re_i(wk_re), .raddr_i(wk_raddr), .rdata_o(wk_rdata)
  );

  assign can_push = !out_vld_q || out_ready_i;
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hix_q} - (NCNT_W+1)'(1);
  assign mkey     = node_rdata ^ SIGN_FLIP;
  assign t_ord    = (t_q == v_q) ? ordv_q : vl_rdata[VL_W-1:ORD_W];

  always_comb begin
    state_d    = state_q;
    nc_d       = nc_q;
    ec_d       = ec_q;
    err_d      = err_q;
    lastkey_d  = lastkey_q;
    r_d        = r_q;
    ord_d      = ord_q;
    comp_d     = comp_q;
    msp_d      = msp_q;
    wsp_d      = wsp_q;
    v_d        = v_q;
    e_d        = e_q;
    vid_d      = vid_q;
    ordv_d     = ordv_q;
    lowv_d     = lowv_q;
    lo_d       = lo_q;
    hix_d      = hix_q;
    mid_d      = mid_q;
    t_d        = t_q;
    tkey_d     = tkey_q;
    w_d        = w_q;
    visited_d  = visited_q;
    onstk_d    = onstk_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_ready_i;

    node_we    = 1'b0;
    node_waddr = nc_q[NIDX_W-1:0];
    node_wdata = node_id_i;
    node_re    = 1'b0;
    node_raddr = v_q;
    edge_we    = 1'b0;
    edge_re    = 1'b0;
    vl_we      = 1'b0;
    vl_waddr   = v_q;
    vl_wdata   = {ordv_q, lowv_q};
    vl_re      = 1'b0;
    vl_raddr   = t_q;
    mem_we     = 1'b0;
    mem_waddr  = msp_q[NIDX_W-1:0];
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = msp_q[NIDX_W-1:0] - NIDX_W'(1);
    wk_we      = 1'b0;
    wk_waddr   = wsp_q[NIDX_W-1:0];
    wk_wdata   = {v_q, e_q};
    wk_re      = 1'b0;
    wk_raddr   = wsp_q[NIDX_W-1:0] - NIDX_W'(1);
    do_visit   = 1'b0;
    vis_idx    = r_q[NIDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (opcode_i)
            OP_NODE: begin
              if (nc_q < NCNT_W'(MAX_NODES) && (nc_q == '0 ||
                  (node_id_i ^ SIGN_FLIP) > (lastkey_q ^ SIGN_FLIP))) begin
                node_we   = 1'b1;
                nc_d      = nc_q + NCNT_W'(1);
                lastkey_d = node_id_i;
              end else begin
                err_d = 1'b1;
              end
            end
            OP_EDGE: begin
              if (ec_q < ECNT_W'(MAX_EDGES)) begin
                edge_we = 1'b1;
                ec_d    = ec_q + ECNT_W'(1);
              end else begin
                err_d = 1'b1;
              end
            end
            OP_RUN: begin
              if (err_q || nc_q == '0) begin
                pend_d     = '{id: '0, comp: '0, last_comp: 1'b0, last_all: 1'b1,
                               status: err_q ? ST_ERROR : ST_EMPTY};
                pend_vld_d = 1'b1;
                nc_d       = '0;
                ec_d       = '0;
                err_d      = 1'b0;
                state_d    = S_FLUSH;
              end else begin
                r_d       = '0;
                ord_d     = '0;
                comp_d    = '0;
                msp_d     = '0;
                wsp_d     = '0;
                visited_d = '0;
                onstk_d   = '0;
                state_d   = S_ROOT;
              end
            end
            default: ;
          endcase
        end
      end
      S_ROOT: begin
        if (r_q == nc_q) begin
          nc_d    = '0;
          ec_d    = '0;
          err_d   = 1'b0;
          state_d = S_FLUSH;
        end else if (visited_q[r_q[NIDX_W-1:0]]) begin
          r_d = r_q + NCNT_W'(1);
        end else begin
          do_visit = 1'b1;
          vis_idx  = r_q[NIDX_W-1:0];
        end
      end
      S_VID: begin
        vid_d   = node_rdata;
        state_d = S_EDGE;
      end
      S_EDGE: begin
        if (e_q == ec_q) begin
          state_d = S_END;
        end else begin
          edge_re = 1'b1;
          e_d     = e_q + ECNT_W'(1);
          state_d = S_ECMP;
        end
      end
      S_ECMP: begin
        if (src_rdata == vid_q) begin
          tkey_d  = tgt_rdata ^ SIGN_FLIP;
          lo_d    = '0;
          hix_d   = nc_q;
          state_d = S_BS;
        end else begin
          state_d = S_EDGE;
        end
      end
      S_BS: begin
        if (lo_q >= hix_q) begin
          state_d = S_EDGE;  // target is not a node
        end else begin
          mid_d      = mid_sum[NIDX_W:1];
          node_re    = 1'b1;
          node_raddr = mid_sum[NIDX_W:1];
          state_d    = S_BSC;
        end
      end
      S_BSC: begin
        if (mkey == tkey_q) begin
          t_d     = mid_q;
          state_d = S_TCHK;
        end else begin
          if (mkey < tkey_q) begin
            lo_d = NCNT_W'(mid_q) + NCNT_W'(1);
          end else begin
            hix_d = NCNT_W'(mid_q);
          end
          state_d = S_BS;
        end
      end
      S_TCHK: begin
        if (!visited_q[t_q]) begin
          wk_we    = 1'b1;
          wsp_d    = wsp_q + NCNT_W'(1);
          vl_we    = 1'b1;
          do_visit = 1'b1;
          vis_idx  = t_q;
        end else if (onstk_q[t_q]) begin
          vl_re   = 1'b1;
          state_d = S_TORD;
        end else begin
          state_d = S_EDGE;
        end
      end
      S_TORD: begin
        if (t_ord < lowv_q) begin
          lowv_d = t_ord;
        end
        state_d = S_EDGE;
      end
      S_END: begin
        vl_we   = 1'b1;
        state_d = (lowv_q == ordv_q) ? S_POP : S_RET;
      end
      S_POP: begin
        mem_re  = 1'b1;
        msp_d   = msp_q - NCNT_W'(1);
        state_d = S_POPW;
      end
      S_POPW: begin
        w_d              = mem_rdata;
        onstk_d[mem_rdata] = 1'b0;
        node_re          = 1'b1;
        node_raddr       = mem_rdata;
        state_d          = S_POPE;
      end
      S_POPE: begin
        if (!pend_vld_q || can_push) begin
          if (pend_vld_q) begin
            out_d     = pend_q;
            out_vld_d = 1'b1;
          end
          pend_d     = '{id: node_rdata, comp: comp_q, last_comp: (w_q == v_q),
                         last_all: 1'b0, status: ST_MEMBER};
          pend_vld_d = 1'b1;
          if (w_q == v_q) begin
            comp_d  = comp_q + COMP_W'(1);
            state_d = S_RET;
          end else begin
            state_d = S_POP;
          end
        end
      end
      S_RET: begin
        if (wsp_q == '0) begin
          r_d     = r_q + NCNT_W'(1);
          state_d = S_ROOT;
        end else begin
          wk_re   = 1'b1;
          wsp_d   = wsp_q - NCNT_W'(1);
          state_d = S_RET1;
        end
      end
      S_RET1: begin
        v_d        = wk_rdata[WK_W-1:ECNT_W];
        e_d        = wk_rdata[ECNT_W-1:0];
        vl_re      = 1'b1;
        vl_raddr   = wk_rdata[WK_W-1:ECNT_W];
        node_re    = 1'b1;
        node_raddr = wk_rdata[WK_W-1:ECNT_W];
        state_d    = S_RET2;
      end
      S_RET2: begin
        // lowv_q still holds the finished child's low link
        ordv_d  = vl_rdata[VL_W-1:ORD_W];
        lowv_d  = (vl_rdata[ORD_W-1:0] < lowv_q) ? vl_rdata[ORD_W-1:0] : lowv_q;
        vid_d   = node_rdata;
        state_d = S_EDGE;
      end
      S_FLUSH: begin
        if (can_push) begin
          out_d          = pend_q;
          out_d.last_all = 1'b1;
          out_vld_d      = 1'b1;
          pend_vld_d     = 1'b0;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // new node: mark, push on member stack, make it the walk top
    if (do_visit) begin
      visited_d[vis_idx] = 1'b1;
      onstk_d[vis_idx]   = 1'b1;
      mem_we             = 1'b1;
      mem_wdata          = vis_idx;
      msp_d              = msp_q + NCNT_W'(1);
      v_d                = vis_idx;
      e_d                = '0;
      ordv_d             = ord_q;
      lowv_d             = ord_q;
      ord_d              = ord_q + ORD_W'(1);
      node_re            = 1'b1;
      node_raddr         = vis_idx;
      state_d            = S_VID;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      nc_q       <= '0;
      ec_q       <= '0;
      err_q      <= 1'b0;
      r_q        <= '0;
      ord_q      <= '0;
      comp_q     <= '0;
      msp_q      <= '0;
      wsp_q      <= '0;
      visited_q  <= '0;
      onstk_q    <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      nc_q       <= nc_d;
      ec_q       <= ec_d;
      err_q      <= err_d;
      r_q        <= r_d;
      ord_q      <= ord_d;
      comp_q     <= comp_d;
      msp_q      <= msp_d;
      wsp_q      <= wsp_d;
      visited_q  <= visited_d;
      onstk_q    <= onstk_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lastkey_q <= lastkey_d;
    v_q       <= v_d;
    e_q       <= e_d;
    vid_q     <= vid_d;
    ordv_q    <= ordv_d;
    lowv_q    <= lowv_d;
    lo_q      <= lo_d;
    hix_q     <= hix_d;
    mid_q     <= mid_d;
    t_q       <= t_d;
    tkey_q    <= tkey_d;
    w_q       <= w_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
  end

  assign in_ready_o          = (state_q == S_IDLE);
  assign out_valid_o         = out_vld_q;
  assign member_id_o         = out_q.id;
  assign component_number_o  = out_q.comp;
  assign last_in_component_o = out_q.last_comp;
  assign last_overall_o      = out_q.last_all;
  assign run_status_o        = out_q.status;

endmodule

// ===== hdl/scc_ram.sv =====
module scc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/scc_checker.sv =====
module scc_checker import scc_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [ID_WIDTH-1:0] member_id_o,
  input logic                       last_in_component_o,
  input logic                       last_overall_o,
  input logic [1:0]                 run_status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(member_id_o))
    else $error("output beat changed while stalled");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_status_o != ST_MEMBER |-> last_overall_o && !last_in_component_o)
    else $error("status beat not marked final");

  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_overall_o && run_status_o == ST_MEMBER |-> last_in_component_o)
    else $error("final member does not close its component");

  a_status_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_status_o != ST_MEMBER |-> member_id_o == '0)
    else $error("status beat carries a member id");

endmodule

bind strongly_connected_components scc_checker u_scc_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i, .member_id_o,
  .last_in_component_o, .last_overall_o, .run_status_o
);

// ===== verif/strongly_connected_components_tb.sv =====
`timescale 1ns / 100ps

// Tarjan SCC block bench. Loads random and directed graphs, runs the search,
// and checks every emitted member beat against an in-bench Tarjan model.
module strongly_connected_components_tb;
  import scc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int DRAIN_CYCLES   = 64;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [1:0]                 opcode_i;
  logic signed [ID_WIDTH-1:0] node_id_i;
  logic signed [ID_WIDTH-1:0] edge_target_id_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [ID_WIDTH-1:0] member_id_o;
  logic [COMP_W-1:0]          component_number_o;
  logic                       last_in_component_o;
  logic                       last_overall_o;
  logic [1:0]                 run_status_o;

  strongly_connected_components dut (.*);

  // Graph model state: sorted id table, edge list, sticky load error.
  logic [ID_WIDTH-1:0] graph_ids [MAX_NODES];
  logic [ID_WIDTH-1:0] edge_src  [MAX_EDGES];
  logic [ID_WIDTH-1:0] edge_dst  [MAX_EDGES];
  int                  graph_nodes;
  int                  graph_edges;
  bit                  graph_error;

  res_t expected_members [$];   // members still owed by the block
  int   mismatches;
  int   quiet_cycles;
  bit   no_idle;                // when set, both sides run without gaps
  int   out_stall;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Index of a loaded id, or -1. Ids are distinct so a scan is enough.
  function automatic int node_index(logic [ID_WIDTH-1:0] id);
    for (int i = 0; i < graph_nodes; i++)
      if (graph_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic void push_member(logic [ID_WIDTH-1:0] id, int comp, bit lastc,
                                      status_e st);
    res_t r;
    r.id        = id;
    r.comp      = comp[COMP_W-1:0];
    r.last_comp = lastc;
    r.last_all  = 1'b0;
    r.status    = st;
    expected_members.push_back(r);
  endfunction

  // Iterative Tarjan over the model tables; members pushed in pop order.
  function automatic void tarjan_components();
    int  ord [MAX_NODES];
    int  low [MAX_NODES];
    bit  seen [MAX_NODES];
    bit  onstk [MAX_NODES];
    int  mstk [MAX_NODES];
    int  wnode [MAX_NODES];
    int  wedge [MAX_NODES];
    int  nxt, comp, msp, wsp, v, e, t, w, p;
    bit  down;
    nxt = 0; comp = 0; msp = 0; wsp = 0;
    for (int i = 0; i < graph_nodes; i++) begin
      seen[i] = 0;
      onstk[i] = 0;
    end
    for (int root = 0; root < graph_nodes; root++) begin
      if (seen[root]) continue;
      seen[root] = 1;
      ord[root] = nxt; low[root] = nxt; nxt++;
      mstk[msp] = root; msp++;
      onstk[root] = 1;
      wnode[wsp] = root; wedge[wsp] = 0; wsp++;
      while (wsp > 0) begin
        v = wnode[wsp-1];
        e = wedge[wsp-1];
        down = 0;
        while (e < graph_edges && !down) begin
          int cur;
          cur = e;
          e++;
          if (edge_src[cur] != graph_ids[v]) continue;
          t = node_index(edge_dst[cur]);
          if (t < 0) continue;
          if (!seen[t]) begin
            wedge[wsp-1] = e;
            seen[t] = 1;
            ord[t] = nxt; low[t] = nxt; nxt++;
            mstk[msp] = t; msp++;
            onstk[t] = 1;
            wnode[wsp] = t; wedge[wsp] = 0; wsp++;
            down = 1;
          end else if (onstk[t] && ord[t] < low[v]) begin
            low[v] = ord[t];
          end
        end
        if (down) continue;
        wedge[wsp-1] = e;
        if (low[v] == ord[v]) begin
          do begin
            msp--;
            w = mstk[msp];
            onstk[w] = 0;
            push_member(graph_ids[w], comp, w == v, ST_MEMBER);
          end while (w != v && msp > 0);
          comp++;
        end
        wsp--;
        if (wsp > 0) begin
          p = wnode[wsp-1];
          if (low[v] < low[p]) low[p] = low[v];
        end
      end
    end
  endfunction

  // Predict the effect of one accepted input beat.
  function automatic void graph_accept(logic [1:0] op, logic [ID_WIDTH-1:0] a,
                                       logic [ID_WIDTH-1:0] b);
    case (op)
      OP_NODE: begin
        if (graph_nodes >= MAX_NODES ||
            (graph_nodes > 0 && $signed(a) <= $signed(graph_ids[graph_nodes-1]))) begin
          graph_error = 1;
        end else begin
          graph_ids[graph_nodes] = a;
          graph_nodes++;
        end
      end
      OP_EDGE: begin
        if (graph_edges >= MAX_EDGES) begin
          graph_error = 1;
        end else begin
          edge_src[graph_edges] = a;
          edge_dst[graph_edges] = b;
          graph_edges++;
        end
      end
      OP_RUN: begin
        if (graph_error)
          push_member('0, 0, 0, ST_ERROR);
        else if (graph_nodes == 0)
          push_member('0, 0, 0, ST_EMPTY);
        else
          tarjan_components();
        expected_members[$].last_all = 1'b1;
        graph_nodes = 0;
        graph_edges = 0;
        graph_error = 0;
      end
      default: ;
    endcase
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int k;
    if (no_idle) return 0;
    k = $urandom_range(0, 19);
    if (k < 12) return 0;
    if (k < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sends one beat; called at a rising edge, returns at a rising edge.
  task automatic send_beat(logic [1:0] op, logic [ID_WIDTH-1:0] a,
                           logic [ID_WIDTH-1:0] b);
    int gap;
    in_valid_i       <= 1'b1;
    opcode_i         <= op;
    node_id_i        <= a;
    edge_target_id_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    graph_accept(op, a, b);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_all_members();
    in_valid_i <= 1'b0;
    while (expected_members.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ID_WIDTH-1:0] rand_id();
    if ($urandom_range(0, 1)) return {$urandom, $urandom};
    return ID_WIDTH'($signed($urandom_range(0, 40)) - 20);
  endfunction

  // Empty graph, unused opcode, then back-to-back empty runs.
  task automatic test_empty_runs();
    send_beat(OP_NONE, {$urandom, $urandom}, {$urandom, $urandom});
    send_beat(OP_RUN, '0, '1);
    send_beat(OP_RUN, '1, '0);
  endtask

  // Duplicate and descending ids set the sticky error; run reports it once.
  task automatic test_load_order();
    send_beat(OP_NODE, 64'sd5, '0);
    send_beat(OP_NODE, 64'sd5, '0);
    send_beat(OP_NODE, 64'sd9, '0);
    send_beat(OP_RUN, '0, '0);
    send_beat(OP_NODE, 64'sd3, '0);
    send_beat(OP_NODE, -64'sd7, '0);
    send_beat(OP_RUN, '0, '0);
  endtask

  // Extreme ids, a cycle across them, self loop, dangling edge ends.
  task automatic test_extreme_ids();
    logic [ID_WIDTH-1:0] mn, mx;
    mn = {1'b1, {(ID_WIDTH-1){1'b0}}};
    mx = {1'b0, {(ID_WIDTH-1){1'b1}}};
    send_beat(OP_NODE, mn, '0);
    send_beat(OP_NODE, '1, '0);
    send_beat(OP_NODE, '0, '0);
    send_beat(OP_NODE, mx, '0);
    send_beat(OP_EDGE, mn, mx);
    send_beat(OP_EDGE, mx, mn);
    send_beat(OP_EDGE, '0, '1);
    send_beat(OP_EDGE, '1, '1);
    send_beat(OP_EDGE, '0, 64'sd77);     // target not a node
    send_beat(OP_EDGE, 64'sd78, '0);     // source not a node
    send_beat(OP_RUN, '0, '0);
  endtask

  // One node too many.
  task automatic test_node_capacity();
    for (int i = 0; i <= MAX_NODES; i++) send_beat(OP_NODE, 64'(i), '0);
    send_beat(OP_RUN, '0, '0);
  endtask

  // Full node table with a sparse edge set: largest run, most members.
  task automatic test_full_graph();
    for (int i = 0; i < MAX_NODES; i++) send_beat(OP_NODE, 64'(i * 3 - 90), '0);
    for (int i = 0; i < MAX_NODES / 2; i++)
      send_beat(OP_EDGE, 64'($urandom_range(0, MAX_NODES-1) * 3 - 90),
                64'($urandom_range(0, MAX_NODES-1) * 3 - 90));
    send_beat(OP_RUN, '0, '0);
  endtask

  // One edge too many.
  task automatic test_edge_capacity();
    send_beat(OP_NODE, 64'sd1, '0);
    for (int i = 0; i <= MAX_EDGES; i++) send_beat(OP_EDGE, 64'sd1, 64'sd1);
    send_beat(OP_RUN, '0, '0);
  endtask

  // Random well-formed graphs with a little noise mixed in.
  task automatic test_random_graphs();
    longint raw [$];
    logic [ID_WIDTH-1:0] ids [$];
    int n, m, sent, graphs;
    sent = 0;
    graphs = 0;
    while (sent < 40) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      raw.delete();
      ids.delete();
      repeat (n) raw.push_back(longint'(rand_id()));
      raw.sort();
      foreach (raw[i]) if (i == 0 || raw[i] != raw[i-1]) ids.push_back(raw[i]);
      foreach (ids[i]) send_beat(OP_NODE, ids[i], {$urandom, $urandom});
      m = $urandom_range(0, 2 * ids.size());
      repeat (m) begin
        logic [ID_WIDTH-1:0] s, d;
        s = ($urandom_range(0, 11) == 0) ? rand_id() : ids[$urandom_range(0, ids.size()-1)];
        d = ($urandom_range(0, 9) == 0) ? rand_id() : ids[$urandom_range(0, ids.size()-1)];
        send_beat(OP_EDGE, s, d);
        case ($urandom_range(0, 59))
          0: send_beat(OP_NONE, {$urandom, $urandom}, {$urandom, $urandom});
          1: send_beat(OP_NODE, ids[0], '0);   // out of order
          default: ;
        endcase
      end
      send_beat(OP_RUN, {$urandom, $urandom}, {$urandom, $urandom});
      sent += ids.size() + m + 1;
      graphs++;
      if (graphs % 4 == 0) begin
        no_idle = ~no_idle;
        wait_all_members();   // sender holds off until the block drains
      end
    end
  endtask

  // Result side: random ready, compare each accepted beat with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i  <= 1'b0;
      out_stall    <= 0;
      quiet_cycles <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_members.size() == 0) begin
          $display("%0t: unexpected member beat id=%0h status=%0d", $time, member_id_o,
                   run_status_o);
          mismatches++;
        end else begin
          res_t x;
          x = expected_members.pop_front();
          if (member_id_o !== x.id) begin
            $display("%0t: member_id expected %0h actual %0h", $time, x.id, member_id_o);
            mismatches++;
          end
          if (component_number_o !== x.comp) begin
            $display("%0t: component_number expected %0d actual %0d", $time, x.comp,
                     component_number_o);
            mismatches++;
          end
          if (last_in_component_o !== x.last_comp) begin
            $display("%0t: last_in_component expected %0b actual %0b", $time, x.last_comp,
                     last_in_component_o);
            mismatches++;
          end
          if (last_overall_o !== x.last_all) begin
            $display("%0t: last_overall expected %0b actual %0b", $time, x.last_all,
                     last_overall_o);
            mismatches++;
          end
          if (run_status_o !== x.status) begin
            $display("%0t: run_status expected %0d actual %0d", $time, x.status,
                     run_status_o);
            mismatches++;
          end
        end
      end
      // watchdog: any accepted beat on either side resets it
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("strongly_connected_components verification failed");
        $finish;
      end
      // ready pattern: stalls mostly short, now and then long
      if (no_idle) begin
        out_ready_i <= 1'b1;
        out_stall   <= 0;
      end else if (out_stall > 0) begin
        out_ready_i <= 1'b0;
        out_stall   <= out_stall - 1;
      end else begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
        out_stall   <= ($urandom_range(0, 29) == 0) ? $urandom_range(10, 40) : 0;
      end
    end
  end

  initial begin
    in_valid_i       = 1'b0;
    opcode_i         = OP_NONE;
    node_id_i        = '0;
    edge_target_id_i = '0;
    graph_nodes      = 0;
    graph_edges      = 0;
    graph_error      = 0;
    mismatches       = 0;
    no_idle          = 0;
    rst_ni           = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_runs();
    test_load_order();
    test_extreme_ids();
    wait_all_members();
    test_node_capacity();
    test_full_graph();
    test_edge_capacity();
    test_random_graphs();

    wait_all_members();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_members.size() == 0)
      $display("strongly_connected_components verification clean");
    else
      $display("strongly_connected_components verification failed");
    $finish;
  end

endmodule

// ===== strongly_connected_components.f =====
hdl/scc_pkg.sv
hdl/scc_ram.sv
hdl/strongly_connected_components.sv
hdl/scc_checker.sv
verif/strongly_connected_components_tb.sv
